FILE: rtl/mtpc_pkg.sv
// shared types for the multi-threshold pulse counter
// the token that walks the cell chain, the report shift control, command and register codes
`timescale 1ns / 1ps

package mtpc_pkg;

    // value width in sixteenths of an ADC count (sample*16 - baseline, negated when polarity is set)
    localparam int VAL_W = 22;
    // threshold width in sixteenths, covers lower + 63*4095 at times 16
    localparam int THR16_W = 24;
    localparam int TOTAL_W = 32;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LOWER     = 3'd0,
        REG_STEP      = 3'd1,
        REG_HOLD_OFF  = 3'd2,
        REG_ROI_START = 3'd3,
        REG_ROI_END   = 3'd4,
        REG_POLARITY  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                      valid;
        logic                      clr;
        logic                      first;
        logic                      tested;
        logic signed [VAL_W-1:0]   v;
        logic signed [VAL_W-1:0]   prev;
        logic signed [THR16_W-1:0] thr16;
    } tok_t;

    typedef struct packed {
        logic load;
        logic shift;
    } rpt_ctl_t;

endpackage

FILE: rtl/mtpc_cell.sv
// one threshold cell: pulse state, hold-off mark, saturating total
// uses mtpc_pkg for the chain token and the report shift control
`timescale 1ns / 1ps

module mtpc_cell import mtpc_pkg::*; #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           hold_off,
    input  logic [11:0]           threshold_step,
    input  tok_t                  tok_in,
    input  logic [INDEX_BITS-1:0] idx_in,
    output tok_t                  tok_out,
    output logic [INDEX_BITS-1:0] idx_out,
    input  rpt_ctl_t              rpt_ctl,
    input  logic [TOTAL_W-1:0]    rpt_in,
    output logic [TOTAL_W-1:0]    rpt_out
);

    localparam int HW = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 1;

    logic                  in_pulse_reg, in_pulse_next;
    logic                  end_valid_reg, end_valid_next;
    logic [INDEX_BITS-1:0] end_idx_reg, end_idx_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [TOTAL_W-1:0]    rpt_reg;
    tok_t                  tok_reg, tok_next;
    logic [INDEX_BITS-1:0] idx_reg;

    logic signed [THR16_W-1:0] v_ext;
    logic                      above, below, rising, falling, allowed;
    logic [HW-1:0]             idx_w, limit_w;

    assign v_ext   = {{(THR16_W-VAL_W){tok_in.v[VAL_W-1]}}, tok_in.v};
    assign above   = v_ext > tok_in.thr16;
    assign below   = v_ext < tok_in.thr16;
    assign rising  = tok_in.v > tok_in.prev;
    assign falling = tok_in.v < tok_in.prev;
    assign idx_w   = HW'(idx_in);
    assign limit_w = HW'(end_idx_reg) + HW'(hold_off);
    assign allowed = !end_valid_reg || (idx_w >= limit_w);

    always_comb begin
        in_pulse_next  = in_pulse_reg;
        end_valid_next = end_valid_reg;
        end_idx_next   = end_idx_reg;
        total_next     = total_reg;
        if (tok_in.valid) begin
            if (tok_in.clr) begin
                total_next = '0;
            end else if (tok_in.first) begin
                in_pulse_next  = 1'b0;
                end_valid_next = 1'b0;
            end else if (tok_in.tested) begin
                // rise and fall exclude each other through the threshold compare
                if (!in_pulse_reg && above && rising && allowed) begin
                    in_pulse_next = 1'b1;
                    if (total_reg != '1) begin
                        total_next = total_reg + 1'b1;
                    end
                end
                if (in_pulse_reg && below && falling) begin
                    in_pulse_next  = 1'b0;
                    end_valid_next = 1'b1;
                    end_idx_next   = idx_in;
                end
            end
        end
        tok_next       = tok_in;
        tok_next.thr16 = tok_in.thr16 + {{(THR16_W-16){1'b0}}, threshold_step, 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pulse_reg  <= 1'b0;
            end_valid_reg <= 1'b0;
            total_reg     <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            in_pulse_reg  <= in_pulse_next;
            end_valid_reg <= end_valid_next;
            total_reg     <= total_next;
            tok_reg       <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_idx_reg <= end_idx_next;
        idx_reg     <= idx_in;
        if (rpt_ctl.load) begin
            rpt_reg <= total_reg;
        end else if (rpt_ctl.shift) begin
            rpt_reg <= rpt_in;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;
    assign rpt_out = rpt_reg;

endmodule

FILE: rtl/multi_threshold_pulse_counter_core.sv
// top level of the multi-threshold pulse counter: front end, cell chain, report sequencer
// depends on mtpc_pkg and mtpc_cell
`timescale 1ns / 1ps

// Usage
// Input channel s_*: one item per command. Sample items (command 0) are taken one
// per cycle except while a report drains the chain; the front end forms the
// baseline-subtracted value and index and sends a token down a chain of
// NUM_THRESHOLDS cells, one cell per cycle, each cell updating its total as it passes.
// Clear items (command 2) ride the same chain; command 3 is taken and dropped.
// A report item (command 1) holds s_ready low until the chain has drained, then all
// totals are copied at once into a shift line and streamed out on m_* as
// NUM_THRESHOLDS items, index 0 first, m_last on the final one. While they stream,
// sample and clear items are still accepted; a second report waits until the
// stream is done.
// When m_ready is low the current entry holds and the shift line stops.
// Configuration writes on cfg_* are always taken (cfg_ready is tied high).
// Reset (aresetn low at a clock edge) clears totals, pulse state, the sample index,
// the previous value and the registers to their defaults; no clearing pass is needed.

module multi_threshold_pulse_counter_core import mtpc_pkg::*; #(
    parameter int NUM_THRESHOLDS = 16,
    parameter int INDEX_BITS     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [15:0]         s_sample,
    input  logic [19:0]         s_baseline_q4,
    input  logic                s_first_of_event,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_threshold_index,
    output logic signed [31:0]  m_threshold_value,
    output logic [31:0]         m_pulse_total,
    output logic                m_last
);

    localparam int RW = (INDEX_BITS > 16) ? INDEX_BITS : 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    // configuration
    logic signed [15:0] lower_reg;
    logic [11:0]        step_reg;
    logic [15:0]        hold_off_reg;
    logic [15:0]        roi_start_reg;
    logic [15:0]        roi_end_reg;
    logic               polarity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg     <= '0;
            step_reg      <= 12'd1;
            hold_off_reg  <= '0;
            roi_start_reg <= '0;
            roi_end_reg   <= '0;
            polarity_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_LOWER:     lower_reg     <= cfg_data;
                REG_STEP:      step_reg      <= cfg_data[11:0];
                REG_HOLD_OFF:  hold_off_reg  <= cfg_data;
                REG_ROI_START: roi_start_reg <= cfg_data;
                REG_ROI_END:   roi_end_reg   <= cfg_data;
                REG_POLARITY:  polarity_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end
    state_t                  state_reg, state_next;
    logic                    s_accept;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] v_sub, v_in, prev_reg;
    logic [INDEX_BITS-1:0]   sample_index_reg, idx_cur;
    logic [RW-1:0]           idx_rw;
    logic                    tested;
    tok_t                    tok0_reg, tok0_next;
    logic [INDEX_BITS-1:0]   idx0_reg;
    logic                    busy;

    assign cmd      = cmd_t'(s_command);
    assign s_ready  = (state_reg == ST_IDLE) ||
                      ((state_reg == ST_SHIFT) && (cmd != CMD_REPORT));
    assign s_accept = s_valid && s_ready;

    assign v_sub   = VAL_W'({2'b00, s_sample, 4'b0000}) - VAL_W'({2'b00, s_baseline_q4});
    assign v_in    = polarity_reg ? -v_sub : v_sub;
    assign idx_cur = s_first_of_event ? '0 : sample_index_reg;
    assign idx_rw  = RW'(idx_cur);
    assign tested  = ((roi_start_reg == '0) && (roi_end_reg == '0)) ||
                     ((idx_rw >= RW'(roi_start_reg)) && (idx_rw < RW'(roi_end_reg)));

    always_comb begin
        tok0_next.valid  = s_accept && ((cmd == CMD_SAMPLE) || (cmd == CMD_CLEAR));
        tok0_next.clr    = (cmd == CMD_CLEAR);
        tok0_next.first  = s_first_of_event;
        tok0_next.tested = tested;
        tok0_next.v      = v_in;
        tok0_next.prev   = prev_reg;
        tok0_next.thr16  = {{(THR16_W-20){lower_reg[15]}}, lower_reg, 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg         <= '0;
            sample_index_reg <= '0;
            tok0_reg.valid   <= 1'b0;
        end else begin
            tok0_reg <= tok0_next;
            if (s_accept && (cmd == CMD_SAMPLE)) begin
                prev_reg         <= v_in;
                sample_index_reg <= idx_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx0_reg <= idx_cur;
    end

    // cell chain
    tok_t                  chain_tok [0:NUM_THRESHOLDS];
    logic [INDEX_BITS-1:0] chain_idx [0:NUM_THRESHOLDS];
    logic [TOTAL_W-1:0]    chain_rpt [0:NUM_THRESHOLDS];
    logic [NUM_THRESHOLDS:0] chain_valid;
    rpt_ctl_t              rpt_ctl;

    assign chain_tok[0]              = tok0_reg;
    assign chain_idx[0]              = idx0_reg;
    assign chain_rpt[NUM_THRESHOLDS] = '0;

    for (genvar k = 0; k < NUM_THRESHOLDS; k++) begin : g_cell
        mtpc_cell #(
            .INDEX_BITS(INDEX_BITS)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .hold_off       (hold_off_reg),
            .threshold_step (step_reg),
            .tok_in         (chain_tok[k]),
            .idx_in         (chain_idx[k]),
            .tok_out        (chain_tok[k+1]),
            .idx_out        (chain_idx[k+1]),
            .rpt_ctl        (rpt_ctl),
            .rpt_in         (chain_rpt[k+1]),
            .rpt_out        (chain_rpt[k])
        );
    end

    for (genvar k = 0; k <= NUM_THRESHOLDS; k++) begin : g_valid
        assign chain_valid[k] = chain_tok[k].valid;
    end

    assign busy = |chain_valid;

    // report sequencer
    logic [5:0]         out_idx_reg;
    logic signed [31:0] out_thr_reg;
    logic               m_accept;

    assign m_valid  = (state_reg == ST_SHIFT);
    assign m_accept = m_valid && m_ready;
    assign m_last   = (out_idx_reg == 6'(NUM_THRESHOLDS - 1));

    assign rpt_ctl.load  = (state_reg == ST_DRAIN) && !busy;
    assign rpt_ctl.shift = m_accept;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (cmd == CMD_REPORT)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (m_accept && m_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (rpt_ctl.load) begin
                out_idx_reg <= '0;
            end else if (m_accept) begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rpt_ctl.load) begin
            out_thr_reg <= {{16{lower_reg[15]}}, lower_reg};
        end else if (m_accept) begin
            out_thr_reg <= out_thr_reg + $signed({20'b0, step_reg});
        end
    end

    assign m_threshold_index = out_idx_reg;
    assign m_threshold_value = out_thr_reg;
    assign m_pulse_total     = chain_rpt[0];

    // snapshot is taken only with the chain empty and starts at entry zero
    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        rpt_ctl.load |=> (state_reg == ST_SHIFT) && (out_idx_reg == '0))
        else $error("report snapshot did not start at entry zero");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_last) |=> !m_valid)
        else $error("report stream continued past the last entry");

    a_no_report_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !(s_accept && (cmd == CMD_REPORT)))
        else $error("report accepted while another was in progress");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (cmd == CMD_SAMPLE) && !s_first_of_event) |=>
        (sample_index_reg == $past(sample_index_reg) + 1'b1))
        else $error("sample index did not advance");

    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> !tok0_reg.valid)
        else $error("token entered the chain while draining");

endmodule

FILE: sim/multi_threshold_pulse_counter_core_tb.sv
`timescale 1ns / 1ps
// testbench for multi_threshold_pulse_counter_core: directed and random sample streams,
// report streams checked against a threshold scan predictor kept in the bench; uses mtpc_pkg

module multi_threshold_pulse_counter_core_tb import mtpc_pkg::*;;

    localparam int NUM_THR       = 16;
    localparam int IDX_BITS      = 16;
    localparam int CYCLE_LIMIT   = 100_000;
    localparam int SETTLE_CYCLES = NUM_THR + 6;

    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] value;
        logic [31:0]        total;
        logic               last;
    } report_entry_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic [15:0]        s_sample;
    logic [19:0]        s_baseline_q4;
    logic               s_first_of_event;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_threshold_index;
    logic signed [31:0] m_threshold_value;
    logic [31:0]        m_pulse_total;
    logic               m_last;

    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;
    int rcv_hold_cycles = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // predictor copy of registers and scan state
    logic signed [15:0]      thr_lower;
    logic [11:0]             thr_step;
    logic [15:0]             holdoff_len;
    logic [15:0]             roi_lo;
    logic [15:0]             roi_hi;
    logic                    negate_v;
    logic                    pulse_open [NUM_THR];
    logic [IDX_BITS-1:0]     end_index [NUM_THR];
    logic                    end_seen [NUM_THR];
    logic [TOTAL_W-1:0]      pulse_count [NUM_THR];
    logic signed [VAL_W-1:0] prev_v;
    logic [IDX_BITS-1:0]     next_index;
    report_entry_t           expected_report[$];

    multi_threshold_pulse_counter_core #(
        .NUM_THRESHOLDS(NUM_THR),
        .INDEX_BITS(IDX_BITS)
    ) u_top (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multi_threshold_pulse_counter_core verification failed");
            $finish;
        end
    end

    // receiver: a long hold-off wins over random stalls
    always @(negedge aclk) begin
        if (rcv_hold_cycles > 0) begin
            m_ready = 1'b0;
            rcv_hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic int threshold_counts(int i);
        return int'(thr_lower) + i * int'(thr_step);
    endfunction

    function automatic void reset_prediction();
        int i;
        thr_lower   = '0;
        thr_step    = 12'd1;
        holdoff_len = '0;
        roi_lo      = '0;
        roi_hi      = '0;
        negate_v    = 1'b0;
        for (i = 0; i < NUM_THR; i++) begin
            pulse_open[i]  = 1'b0;
            end_index[i]   = '0;
            end_seen[i]    = 1'b0;
            pulse_count[i] = '0;
        end
        prev_v     = '0;
        next_index = '0;
    endfunction

    function automatic void scan_sample(logic [15:0] smp, logic [19:0] base, logic first_mark);
        logic signed [VAL_W-1:0] v;
        logic [IDX_BITS-1:0]     idx;
        logic                    tested;
        int                      t16;
        int                      i;
        v = $signed({2'b00, smp, 4'b0000}) - $signed({2'b00, base});
        if (negate_v)
            v = -v;
        if (first_mark) begin
            idx = '0;
            for (i = 0; i < NUM_THR; i++) begin
                pulse_open[i] = 1'b0;
                end_seen[i]   = 1'b0;
            end
        end else begin
            idx = next_index;
        end
        if (roi_lo == 0 && roi_hi == 0)
            tested = 1'b1;
        else
            tested = (idx >= roi_lo) && (idx < roi_hi);
        // an event's first sample has no predecessor and never crosses
        if (tested && !first_mark) begin
            for (i = 0; i < NUM_THR; i++) begin
                t16 = threshold_counts(i) * 16;
                if (!pulse_open[i] && int'(v) > t16 && v > prev_v) begin
                    if (!end_seen[i] || 32'(idx) >= 32'(end_index[i]) + 32'(holdoff_len)) begin
                        if (pulse_count[i] != '1)
                            pulse_count[i]++;
                        pulse_open[i] = 1'b1;
                    end
                end
                if (pulse_open[i] && int'(v) < t16 && v < prev_v) begin
                    pulse_open[i] = 1'b0;
                    end_index[i]  = idx;
                    end_seen[i]   = 1'b1;
                end
            end
        end
        prev_v     = v;
        next_index = idx + 1'b1;
    endfunction

    function automatic void predict_accept(cmd_t cmd, logic [15:0] smp, logic [19:0] base,
                                           logic first_mark);
        report_entry_t e;
        int            i;
        case (cmd)
            CMD_SAMPLE: begin
                scan_sample(smp, base, first_mark);
            end
            CMD_REPORT: begin
                for (i = 0; i < NUM_THR; i++) begin
                    e.index = 6'(i);
                    e.value = 32'(threshold_counts(i));
                    e.total = pulse_count[i];
                    e.last  = (i == NUM_THR - 1);
                    expected_report.push_back(e);
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < NUM_THR; i++)
                    pulse_count[i] = '0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_report
        report_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_report.size() == 0) begin
                mismatch_count++;
                $display("%0t: report item with none expected, index %0d total %0d",
                         $time, m_threshold_index, m_pulse_total);
            end else begin
                want = expected_report.pop_front();
                compare_field("threshold_index", 32'(want.index), 32'(m_threshold_index));
                compare_field("threshold_value", want.value, m_threshold_value);
                compare_field("pulse_total", want.total, m_pulse_total);
                compare_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // stimulus tasks enter and leave just after a falling edge
    task automatic send_item(cmd_t cmd, logic [15:0] smp, logic [19:0] base, logic first_mark);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_command        = cmd;
        s_sample         = smp;
        s_baseline_q4    = base;
        s_first_of_event = first_mark;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_accept(cmd, smp, base, first_mark);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_report();
        send_item(CMD_REPORT, 16'($urandom), 20'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(reg_idx_t r, logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (r)
            REG_LOWER:     thr_lower   = data;
            REG_STEP:      thr_step    = data[11:0];
            REG_HOLD_OFF:  holdoff_len = data;
            REG_ROI_START: roi_lo      = data;
            REG_ROI_END:   roi_hi      = data;
            REG_POLARITY:  negate_v    = data[0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // samples give no result, so let the cell chain drain as well
    task automatic settle();
        while (expected_report.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_regs(logic [15:0] lower, logic [11:0] step, logic [15:0] hold,
                                logic [15:0] rs, logic [15:0] re, logic pol);
        settle();
        write_reg(REG_LOWER, lower);
        write_reg(REG_STEP, 16'(step));
        write_reg(REG_HOLD_OFF, hold);
        write_reg(REG_ROI_START, rs);
        write_reg(REG_ROI_END, re);
        write_reg(REG_POLARITY, 16'(pol));
    endtask

    task automatic set_idle(int src, int snk);
        @(posedge aclk);
        src_idle_pct  = src;
        snk_stall_pct = snk;
        @(negedge aclk);
    endtask

    // raw sample that lands near the wanted value in sixteenths
    function automatic logic [15:0] raw_for(int v16, logic [19:0] base);
        int num;
        num = negate_v ? int'(base) - v16 : int'(base) + v16;
        if (num < 0)
            return 16'd0;
        if (num > 65535 * 16)
            return 16'hffff;
        return 16'(num >>> 4);
    endfunction

    task automatic send_event(int len);
        logic [19:0] base;
        int          lo;
        int          span;
        int          k;
        lo   = (threshold_counts(0) - 6) * 16;
        span = (threshold_counts(NUM_THR - 1) + 6) * 16 - lo;
        if ($urandom_range(3) == 0)
            base = 20'($urandom);
        else
            base = 20'(524288 + $urandom_range(0, 4095));
        for (k = 0; k < len; k++)
            send_item(CMD_SAMPLE, raw_for(lo + int'($urandom_range(0, span)), base), base,
                      k == 0);
    endtask

    // event of alternating low and high samples, meant for lower 0, step 1, positive
    task automatic send_pulse_train(int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(CMD_SAMPLE, (k % 2) ? 16'd30 : 16'd0, 20'd80, k == 0);
    endtask

    task automatic test_directed();
        send_item(CMD_SAMPLE, 16'd0, 20'd0, 1'b0);
        send_item(CMD_SAMPLE, 16'hffff, 20'd0, 1'b0);
        send_item(CMD_SAMPLE, 16'd0, 20'hfffff, 1'b0);
        send_item(CMD_SAMPLE, 16'hffff, 20'hfffff, 1'b1);
        send_item(CMD_SAMPLE, 16'd100, 20'd0, 1'b0);
        send_item(CMD_SAMPLE, 16'd2, 20'd0, 1'b0);
        send_item(CMD_UNUSED, 16'hffff, 20'hfffff, 1'b1);
        send_item(CMD_SAMPLE, 16'd50, 20'd0, 1'b0);
        send_report();
        send_item(CMD_CLEAR, 16'hffff, 20'hfffff, 1'b1);
        send_report();
        send_item(CMD_SAMPLE, 16'd0, 20'd0, 1'b1);
        send_item(CMD_SAMPLE, 16'd9, 20'd0, 1'b0);
        send_report();
    endtask

    task automatic test_hold_off();
        program_regs(16'd0, 12'd1, 16'd3, 16'd0, 16'd0, 1'b0);
        send_pulse_train(14);
        send_report();
        program_regs(16'd0, 12'd1, 16'hffff, 16'd0, 16'd0, 1'b0);
        send_pulse_train(10);
        send_report();
        program_regs(16'd0, 12'd1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pulse_train(10);
        send_report();
    endtask

    task automatic test_roi();
        program_regs(16'd0, 12'd1, 16'd0, 16'd3, 16'd7, 1'b0);
        send_pulse_train(12);
        send_report();
        // empty window
        program_regs(16'd0, 12'd1, 16'd0, 16'd5, 16'd5, 1'b0);
        send_pulse_train(10);
        send_report();
        program_regs(16'd0, 12'd1, 16'd0, 16'd0, 16'hffff, 1'b0);
        send_pulse_train(8);
        send_report();
        program_regs(16'd0, 12'd1, 16'd0, 16'hffff, 16'd0, 1'b0);
        send_pulse_train(8);
        send_report();
    endtask

    task automatic test_threshold_extremes();
        program_regs(16'h8000, 12'hfff, 16'd0, 16'd0, 16'd0, 1'b1);
        send_event(8);
        send_event(6);
        send_report();
        program_regs(16'h7fff, 12'hfff, 16'd1, 16'd0, 16'd0, 1'b0);
        send_event(8);
        send_report();
        program_regs(16'h7fff, 12'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_event(6);
        send_report();
    endtask

    task automatic test_backpressure();
        set_idle(0, 20);
        program_regs(16'hfffc, 12'd2, 16'd1, 16'd0, 16'd0, 1'b0);
        @(posedge aclk);
        rcv_hold_cycles = 150;
        @(negedge aclk);
        // second report must wait until the first stream drains
        send_report();
        send_event(10);
        send_report();
        send_event(10);
        send_report();
        settle();
        send_event(8);
        send_report();
    endtask

    task automatic test_random_phases();
        int src_modes[4] = '{0, 62, 0, 12};
        int snk_modes[4] = '{0, 0, 62, 12};
        int m;
        int p;
        int sent;
        int r;
        int len;
        for (m = 0; m < 4; m++) begin
            set_idle(src_modes[m], snk_modes[m]);
            for (p = 0; p < 2; p++) begin
                if ($urandom_range(1))
                    program_regs(16'($urandom_range(0, 80) - 40), 12'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 4)), 16'd0, 16'd0, 1'($urandom));
                else
                    program_regs(16'($urandom_range(0, 80) - 40), 12'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 14)), 1'($urandom));
                sent = 0;
                while (sent < 32) begin
                    r = $urandom_range(99);
                    if (r < 6) begin
                        send_report();
                        sent++;
                    end else if (r < 8) begin
                        send_item(CMD_CLEAR, 16'($urandom), 20'($urandom), 1'($urandom));
                        sent++;
                    end else if (r < 10) begin
                        send_item(CMD_UNUSED, 16'($urandom), 20'($urandom), 1'($urandom));
                    end else if (r < 18) begin
                        send_item(CMD_SAMPLE, 16'($urandom), 20'($urandom), 1'($urandom));
                        sent++;
                    end else begin
                        len = $urandom_range(3, 16);
                        send_event(len);
                        sent += len;
                    end
                end
                send_report();
            end
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_LOWER;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_command        = CMD_SAMPLE;
        s_sample         = '0;
        s_baseline_q4    = '0;
        s_first_of_event = 1'b0;
        reset_prediction();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_hold_off();
        test_roi();
        test_threshold_extremes();
        test_backpressure();
        test_random_phases();

        while (expected_report.size() != 0)
            @(negedge aclk);
        repeat (2 * NUM_THR + 8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("multi_threshold_pulse_counter_core verification clean");
        end else begin
            $display("multi_threshold_pulse_counter_core verification failed");
        end
        $finish;
    end

endmodule
